[hdl/grse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package grse_pkg;

  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 9;
  localparam int LAND_W     = 16;
  localparam int CELL_W     = 10;
  localparam int INDEX_W    = 20;
  localparam int QUOT_W     = 16;
  localparam int DIVISOR_W  = 11;
  localparam int RECIP_W    = 32;
  localparam int RECIP_SHIFT = 31;
  localparam int TAG_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_RESULTS = 26;
  localparam int COUNT_W    = 5;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam int DEF_SECTOR_WIDTH  = 64;
  localparam int DEF_SECTOR_HEIGHT = 64;

  localparam logic [LAND_W-1:0] LAND_RESET = 16'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LANDSCAPE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDSCAPE_HEIGHT = 1'b1;

  // Division jobs, issued in this order.
  localparam logic [TAG_W-1:0] TAG_GRIDW = 3'd0;
  localparam logic [TAG_W-1:0] TAG_ROW0  = 3'd1;
  localparam logic [TAG_W-1:0] TAG_COL0  = 3'd2;
  localparam logic [TAG_W-1:0] TAG_COL1  = 3'd3;
  localparam logic [TAG_W-1:0] TAG_ROW1  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_CLIP,
    ST_EXT,
    ST_DIV,
    ST_WAIT,
    ST_MUL,
    ST_WALK,
    ST_OUTS
  } grse_state_t;

  typedef struct packed {
    logic             load;
    logic             norm;
    logic             clip;
    logic             ext;
    logic             div_issue;
    logic [TAG_W-1:0] div_tag;
    logic             walk_init;
    logic             emit_cell;
    logic             emit_outside;
  } grse_cmd_t;

  typedef struct packed {
    logic in_range;
    logic outside;
    logic out_free;
    logic div_last;
    logic walk_end;
    logic at_cap;
  } grse_status_t;

endpackage

`default_nettype wire

[hdl/grse_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Three-stage divider by one of two constant divisors: multiply by a
// truncated reciprocal, then correct the estimate by at most one.
module grse_div #(
  parameter int SECTOR_WIDTH  = grse_pkg::DEF_SECTOR_WIDTH,
  parameter int SECTOR_HEIGHT = grse_pkg::DEF_SECTOR_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          axis_h,
  input  wire logic [grse_pkg::TAG_W-1:0]    tag_in,
  input  wire logic [grse_pkg::QUOT_W-1:0]   dividend,
  output logic                               done,
  output logic [grse_pkg::TAG_W-1:0]         tag_out,
  output logic [grse_pkg::QUOT_W-1:0]        quotient
);

  localparam int QW = grse_pkg::QUOT_W;
  localparam int DW = grse_pkg::DIVISOR_W;
  localparam int RW = grse_pkg::RECIP_W;
  localparam int PW = QW + RW;
  localparam int MW = QW + DW;

  localparam logic [RW-1:0] RECIP_X =
    RW'((64'd1 << grse_pkg::RECIP_SHIFT) / 64'(SECTOR_WIDTH));
  localparam logic [RW-1:0] RECIP_Y =
    RW'((64'd1 << grse_pkg::RECIP_SHIFT) / 64'(SECTOR_HEIGHT));
  localparam logic [DW-1:0] DIV_X = DW'(SECTOR_WIDTH);
  localparam logic [DW-1:0] DIV_Y = DW'(SECTOR_HEIGHT);

  logic                          vld1_r, vld2_r, vld3_r;
  logic [grse_pkg::TAG_W-1:0]    tag1_r, tag2_r, tag3_r;
  logic                          h1_r, h2_r;
  logic [QW-1:0]                 v1_r, v2_r;
  logic [PW-1:0]                 prod1_r, prod1_nxt;
  logic [QW-1:0]                 qe2_r, qe_nxt;
  logic [MW-1:0]                 prod2_r, prod2_nxt;
  logic [QW-1:0]                 q3_r, q3_nxt;
  logic [QW-1:0]                 rem;
  logic [DW-1:0]                 d2;

  assign prod1_nxt = {{QW{1'b0}}, (axis_h ? RECIP_Y : RECIP_X)} * {{RW{1'b0}}, dividend};
  assign qe_nxt    = prod1_r[grse_pkg::RECIP_SHIFT +: QW];
  assign prod2_nxt = {{DW{1'b0}}, qe_nxt} * {{QW{1'b0}}, (h1_r ? DIV_Y : DIV_X)};
  assign d2        = h2_r ? DIV_Y : DIV_X;
  assign rem       = v2_r - prod2_r[QW-1:0];
  assign q3_nxt    = qe2_r + {{(QW-1){1'b0}}, (rem >= {{(QW-DW){1'b0}}, d2})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= start;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r  <= tag_in;
    h1_r    <= axis_h;
    v1_r    <= dividend;
    prod1_r <= prod1_nxt;
    tag2_r  <= tag1_r;
    h2_r    <= h1_r;
    v2_r    <= v1_r;
    qe2_r   <= qe_nxt;
    prod2_r <= prod2_nxt;
    tag3_r  <= tag2_r;
    q3_r    <= q3_nxt;
  end

  assign done     = vld3_r;
  assign tag_out  = tag3_r;
  assign quotient = q3_r;

endmodule

`default_nettype wire

[hdl/grse_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module grse_dp #(
  parameter int SECTOR_WIDTH  = grse_pkg::DEF_SECTOR_WIDTH,
  parameter int SECTOR_HEIGHT = grse_pkg::DEF_SECTOR_HEIGHT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire grse_pkg::grse_cmd_t                  cmd,
  output grse_pkg::grse_status_t                    status,
  input  wire logic signed [grse_pkg::COORD_W-1:0]  rect_left,
  input  wire logic signed [grse_pkg::COORD_W-1:0]  rect_top,
  input  wire logic signed [grse_pkg::SIZE_W-1:0]   rect_width,
  input  wire logic signed [grse_pkg::SIZE_W-1:0]   rect_height,
  input  wire logic                                 cfg_we,
  input  wire logic [grse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [grse_pkg::LAND_W-1:0]          cfg_data,
  input  wire logic                                 out_tready,
  output logic                                      out_tvalid,
  output logic [grse_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                      out_tlast,
  output logic                                      out_tuser
);

  localparam int LW = grse_pkg::LAND_W;
  localparam int QW = grse_pkg::QUOT_W;
  localparam int CW = grse_pkg::CELL_W;
  localparam int IW = grse_pkg::INDEX_W;
  localparam int NW = grse_pkg::COUNT_W;

  // Clipped position in the upper 16 bits, clipped length in the lower 9.
  function automatic logic [24:0] clip_axis(input logic signed [18:0] pos,
                                            input logic signed [18:0] len,
                                            input logic signed [18:0] blen);
    logic signed [18:0] sum;
    logic signed [18:0] p;
    logic signed [18:0] l;
    sum = pos + len;
    p = pos;
    l = len;
    if (pos < 19'sd0) begin
      p = 19'sd0;
      if (blen < sum) begin
        l = blen;
      end else begin
        l = len + pos;
      end
    end else if (blen < sum) begin
      l = blen - pos;
    end
    if (l < 19'sd0) begin
      l = 19'sd0;
    end
    return {p[15:0], l[8:0]};
  endfunction

  function automatic logic inside_axis(input logic signed [18:0] pos,
                                       input logic signed [18:0] len,
                                       input logic signed [18:0] blen);
    logic signed [18:0] tail;
    tail = pos + len - 19'sd1;
    return (pos >= 19'sd0) && (pos < blen) && (tail >= 19'sd0) && (tail < blen);
  endfunction

  logic [LW-1:0]        lw_r, lh_r;
  logic signed [17:0]   x_r, y_r;
  logic signed [9:0]    w_r, h_r;
  logic [LW-1:0]        xc_r, yc_r, xe_r, ye_r;
  logic [8:0]           wc_r, hc_r;
  logic                 outside_r;
  logic [QW-1:0]        gridw_r, col0_r, col1_r, row0_r, row1_r;
  logic [QW-1:0]        col_cnt_r, row_cnt_r;
  logic [IW-1:0]        rowbase_r;
  logic [NW-1:0]        n_r;
  logic                 ov_r;
  logic [CW-1:0]        out_col_r, out_row_r;
  logic [IW-1:0]        out_idx_r;
  logic                 out_last_r, out_outside_r;

  logic signed [18:0]   bw, bh;
  logic [24:0]          clip_x, clip_y;
  logic                 contained;
  logic [8:0]           wc1, hc1;
  logic [QW-1:0]        div_dividend;
  logic                 div_axis_h;
  logic                 div_done;
  logic [grse_pkg::TAG_W-1:0] div_tag;
  logic [QW-1:0]        div_q;
  logic                 row_end, walk_end, at_cap, out_free;
  logic [2*QW-1:0]      base_prod;

  assign bw = signed'({3'b000, lw_r});
  assign bh = signed'({3'b000, lh_r});
  assign clip_x = clip_axis(19'(x_r), 19'(w_r), bw);
  assign clip_y = clip_axis(19'(y_r), 19'(h_r), bh);
  assign contained = inside_axis(19'(x_r), 19'(w_r), bw) &&
                     inside_axis(19'(y_r), 19'(h_r), bh);

  // A clipped size of zero still covers one pixel.
  assign wc1 = (wc_r == 9'd0) ? 9'd1 : wc_r;
  assign hc1 = (hc_r == 9'd0) ? 9'd1 : hc_r;

  always_comb begin
    div_dividend = xc_r;
    div_axis_h   = 1'b0;
    case (cmd.div_tag)
      grse_pkg::TAG_GRIDW: div_dividend = lw_r - 16'd1;
      grse_pkg::TAG_ROW0: begin
        div_dividend = yc_r;
        div_axis_h   = 1'b1;
      end
      grse_pkg::TAG_COL0:  div_dividend = xc_r;
      grse_pkg::TAG_COL1:  div_dividend = xe_r;
      grse_pkg::TAG_ROW1: begin
        div_dividend = ye_r;
        div_axis_h   = 1'b1;
      end
      default: div_dividend = xc_r;
    endcase
  end

  grse_div #(
    .SECTOR_WIDTH  (SECTOR_WIDTH),
    .SECTOR_HEIGHT (SECTOR_HEIGHT)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_issue),
    .axis_h   (div_axis_h),
    .tag_in   (cmd.div_tag),
    .dividend (div_dividend),
    .done     (div_done),
    .tag_out  (div_tag),
    .quotient (div_q)
  );

  assign row_end   = (col_cnt_r == col1_r);
  assign walk_end  = row_end && (row_cnt_r == row1_r);
  assign at_cap    = (n_r == NW'(grse_pkg::MAX_RESULTS - 1));
  assign out_free  = !ov_r || out_tready;
  assign base_prod = row0_r * gridw_r;

  assign status.in_range = (xc_r < lw_r) && (yc_r < lh_r);
  assign status.outside  = outside_r;
  assign status.out_free = out_free;
  assign status.div_last = div_done && (div_tag == grse_pkg::TAG_ROW1);
  assign status.walk_end = walk_end;
  assign status.at_cap   = at_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= grse_pkg::LAND_RESET;
      lh_r <= grse_pkg::LAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        grse_pkg::CFG_LANDSCAPE_WIDTH:  lw_r <= cfg_data;
        grse_pkg::CFG_LANDSCAPE_HEIGHT: lh_r <= cfg_data;
        default: lw_r <= lw_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_cell || cmd.emit_outside) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= 18'(rect_left);
      y_r <= 18'(rect_top);
      w_r <= 10'(rect_width);
      h_r <= 10'(rect_height);
    end
    // A negative size moves the corner and flips the sign.
    if (cmd.norm) begin
      if (w_r < 10'sd0) begin
        x_r <= x_r + 18'(w_r);
        w_r <= -w_r;
      end
      if (h_r < 10'sd0) begin
        y_r <= y_r + 18'(h_r);
        h_r <= -h_r;
      end
    end
    if (cmd.clip) begin
      xc_r      <= clip_x[24:9];
      wc_r      <= clip_x[8:0];
      yc_r      <= clip_y[24:9];
      hc_r      <= clip_y[8:0];
      outside_r <= !contained;
    end
    if (cmd.ext) begin
      xe_r <= xc_r + 16'(wc1) - 16'd1;
      ye_r <= yc_r + 16'(hc1) - 16'd1;
    end
    if (div_done) begin
      case (div_tag)
        grse_pkg::TAG_GRIDW: gridw_r <= div_q + 16'd1;
        grse_pkg::TAG_ROW0:  row0_r  <= div_q;
        grse_pkg::TAG_COL0:  col0_r  <= div_q;
        grse_pkg::TAG_COL1:  col1_r  <= div_q;
        grse_pkg::TAG_ROW1:  row1_r  <= div_q;
        default: row1_r <= row1_r;
      endcase
    end
    if (cmd.walk_init) begin
      rowbase_r <= base_prod[IW-1:0];
      col_cnt_r <= col0_r;
      row_cnt_r <= row0_r;
      n_r       <= '0;
    end
    if (cmd.emit_cell) begin
      out_col_r     <= col_cnt_r[CW-1:0];
      out_row_r     <= row_cnt_r[CW-1:0];
      out_idx_r     <= rowbase_r + IW'(col_cnt_r);
      out_outside_r <= 1'b0;
      out_last_r    <= (walk_end && !outside_r) || at_cap;
      n_r           <= n_r + 5'd1;
      if (row_end) begin
        col_cnt_r <= col0_r;
        row_cnt_r <= row_cnt_r + 16'd1;
        rowbase_r <= rowbase_r + IW'(gridw_r);
      end else begin
        col_cnt_r <= col_cnt_r + 16'd1;
      end
    end
    if (cmd.emit_outside) begin
      out_col_r     <= '0;
      out_row_r     <= '0;
      out_idx_r     <= '0;
      out_outside_r <= 1'b1;
      out_last_r    <= 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {out_idx_r, out_row_r, out_col_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_outside_r;

endmodule

`default_nettype wire

[hdl/grse_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module grse_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire grse_pkg::grse_status_t status,
  output grse_pkg::grse_cmd_t         cmd
);

  grse_pkg::grse_state_t      state_r, state_nxt;
  logic [grse_pkg::TAG_W-1:0] tag_r, tag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grse_pkg::ST_IDLE;
      tag_r   <= grse_pkg::TAG_GRIDW;
    end else begin
      state_r <= state_nxt;
      tag_r   <= tag_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tag_nxt   = tag_r;
    case (state_r)
      grse_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = grse_pkg::ST_NORM;
      end
      grse_pkg::ST_NORM: state_nxt = grse_pkg::ST_CLIP;
      grse_pkg::ST_CLIP: state_nxt = grse_pkg::ST_EXT;
      grse_pkg::ST_EXT: begin
        tag_nxt   = grse_pkg::TAG_GRIDW;
        state_nxt = status.in_range ? grse_pkg::ST_DIV : grse_pkg::ST_OUTS;
      end
      grse_pkg::ST_DIV: begin
        tag_nxt = tag_r + 3'd1;
        if (tag_r == grse_pkg::TAG_ROW1) begin
          tag_nxt   = grse_pkg::TAG_GRIDW;
          state_nxt = grse_pkg::ST_WAIT;
        end
      end
      grse_pkg::ST_WAIT: begin
        if (status.div_last) state_nxt = grse_pkg::ST_MUL;
      end
      grse_pkg::ST_MUL: state_nxt = grse_pkg::ST_WALK;
      grse_pkg::ST_WALK: begin
        if (status.out_free) begin
          if (status.at_cap) begin
            state_nxt = grse_pkg::ST_IDLE;
          end else if (status.walk_end) begin
            state_nxt = status.outside ? grse_pkg::ST_OUTS : grse_pkg::ST_IDLE;
          end
        end
      end
      grse_pkg::ST_OUTS: begin
        if (status.out_free) state_nxt = grse_pkg::ST_IDLE;
      end
      default: state_nxt = grse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      grse_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      grse_pkg::ST_NORM: cmd.norm = 1'b1;
      grse_pkg::ST_CLIP: cmd.clip = 1'b1;
      grse_pkg::ST_EXT:  cmd.ext  = 1'b1;
      grse_pkg::ST_DIV: begin
        cmd.div_issue = 1'b1;
        cmd.div_tag   = tag_r;
      end
      grse_pkg::ST_WAIT: cmd.div_tag = tag_r;
      grse_pkg::ST_MUL:  cmd.walk_init = 1'b1;
      grse_pkg::ST_WALK: cmd.emit_cell = status.out_free;
      grse_pkg::ST_OUTS: cmd.emit_outside = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/grid_rect_sector_enumerator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Beat contents
// in_      slave      tdata: rect_left[15:0], rect_top[31:16], rect_width[40:32],
//                     rect_height[49:41], zero pad to 56 bits
// out_     master     tdata: cell_column, cell_row, cell_index; tuser: is_outside;
//                     tlast: is_last
// cfg_     slave      index 0 landscape_width, 1 landscape_height; data 16 bits
//
// After the accepting beat, set-up steps through normalise, clip, end points, five
// divisions through the three-stage reciprocal divider and the row base multiply; then
// the walk gives one result beat per cycle while the output is free, at most 26.
// Reset is synchronous and active low; both landscape sizes return to 1024.
// A stalled output holds the walk while it stalls; a new rectangle is taken while the
// last beat of the previous one still waits in the output register.
module grid_rect_sector_enumerator #(
  parameter int SECTOR_WIDTH  = grse_pkg::DEF_SECTOR_WIDTH,
  parameter int SECTOR_HEIGHT = grse_pkg::DEF_SECTOR_HEIGHT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // rect_left, rect_top, rect_width, rect_height, zero pad
  input  wire logic [grse_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // cell_column, cell_row, cell_index
  output logic [grse_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                     out_tlast,
  // is_outside
  output logic                                     out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [grse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [grse_pkg::LAND_W-1:0]         cfg_data
);

  grse_pkg::grse_cmd_t    cmd;
  grse_pkg::grse_status_t status;

  assign cfg_ready = 1'b1;

  grse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  grse_dp #(
    .SECTOR_WIDTH  (SECTOR_WIDTH),
    .SECTOR_HEIGHT (SECTOR_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .rect_left   (in_tdata[15:0]),
    .rect_top    (in_tdata[31:16]),
    .rect_width  (in_tdata[40:32]),
    .rect_height (in_tdata[49:41]),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int SECT_W         = grse_pkg::DEF_SECTOR_WIDTH;
  localparam int SECT_H         = grse_pkg::DEF_SECTOR_HEIGHT;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [grse_pkg::CELL_W-1:0]  col;
    logic [grse_pkg::CELL_W-1:0]  row;
    logic [grse_pkg::INDEX_W-1:0] idx;
    logic                         outside;
    logic                         last;
  } cell_beat_t;

  // Holds its own copy of the landscape size and the cells still owed by the block.
  class cell_scoreboard;
    int unsigned land_w;
    int unsigned land_h;
    cell_beat_t  owed_cells[$];
    int          errors;

    function new();
      land_w = 1024;
      land_h = 1024;
      errors = 0;
    endfunction

    function void clip_span(inout int pos, inout int len, input int span);
      if (pos < 0) begin
        if (span < pos + len) begin
          pos = 0;
          len = span;
        end else begin
          len = len + pos;
          pos = 0;
        end
      end else if (span < pos + len) begin
        len = span - pos;
      end
      if (len < 0) len = 0;
    endfunction

    function void owe_cell(input int col, input int row, input int idx, input bit outside);
      cell_beat_t b;
      b.col     = col[grse_pkg::CELL_W-1:0];
      b.row     = row[grse_pkg::CELL_W-1:0];
      b.idx     = idx[grse_pkg::INDEX_W-1:0];
      b.outside = outside;
      b.last    = 1'b0;
      owed_cells.push_back(b);
    endfunction

    function void note_rect(input logic [grse_pkg::IN_TDATA_W-1:0] d);
      int x, y, w, h, lw, lh, gridw, c0, r0, c1, r1, n;
      bit clipped;
      x  = $signed(d[15:0]);
      y  = $signed(d[31:16]);
      w  = $signed(d[40:32]);
      h  = $signed(d[49:41]);
      lw = land_w;
      lh = land_h;
      gridw = (lw - 1) / SECT_W + 1;
      clipped = 1'b0;
      n = 0;
      if (w < 0) begin
        x = x + w;
        w = -w;
      end
      if (h < 0) begin
        y = y + h;
        h = -h;
      end
      // Containment looks at the first and the last pixel on each axis.
      if (!(x >= 0 && y >= 0 && x < lw && y < lh && x + w - 1 >= 0 && y + h - 1 >= 0 &&
            x + w - 1 < lw && y + h - 1 < lh)) begin
        clip_span(x, w, lw);
        clip_span(y, h, lh);
        clipped = 1'b1;
      end
      if (x >= 0 && y >= 0 && x < lw && y < lh) begin
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        c0 = x / SECT_W;
        r0 = y / SECT_H;
        c1 = (x + w - 1) / SECT_W;
        r1 = (y + h - 1) / SECT_H;
        for (int r = r0; r <= r1 && n < grse_pkg::MAX_RESULTS; r++) begin
          for (int c = c0; c <= c1 && n < grse_pkg::MAX_RESULTS; c++) begin
            owe_cell(c, r, r * gridw + c, 1'b0);
            n++;
          end
        end
        if (clipped && n < grse_pkg::MAX_RESULTS) owe_cell(0, 0, 0, 1'b1);
      end else begin
        owe_cell(0, 0, 0, 1'b1);
      end
      owed_cells[owed_cells.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(input logic [grse_pkg::OUT_TDATA_W-1:0] d, input logic user,
                             input logic last);
      cell_beat_t e;
      if (owed_cells.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %b tlast %b", d, user, last);
        errors++;
        return;
      end
      e = owed_cells.pop_front();
      if (d[grse_pkg::CELL_W-1:0] !== e.col) begin
        $error("cell_column: expected %0d, got %0d", e.col, d[grse_pkg::CELL_W-1:0]);
        errors++;
      end
      if (d[2*grse_pkg::CELL_W-1:grse_pkg::CELL_W] !== e.row) begin
        $error("cell_row: expected %0d, got %0d", e.row,
               d[2*grse_pkg::CELL_W-1:grse_pkg::CELL_W]);
        errors++;
      end
      if (d[2*grse_pkg::CELL_W+grse_pkg::INDEX_W-1:2*grse_pkg::CELL_W] !== e.idx) begin
        $error("cell_index: expected %0d, got %0d", e.idx,
               d[2*grse_pkg::CELL_W+grse_pkg::INDEX_W-1:2*grse_pkg::CELL_W]);
        errors++;
      end
      if (user !== e.outside) begin
        $error("is_outside: expected %0d, got %0d", e.outside, user);
        errors++;
      end
      if (last !== e.last) begin
        $error("is_last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [grse_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [grse_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                out_tlast;
  logic                                out_tuser;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [grse_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [grse_pkg::LAND_W-1:0]         cfg_data = '0;
  logic                                hold_req = 1'b0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  cell_scoreboard sb = new();

  grid_rect_sector_enumerator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser, out_tlast);
  end

  // The receiver stalls at random, and once holds off for a long stretch of its own count.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [grse_pkg::IN_TDATA_W-1:0] pack_rect(input int x, input int y,
                                                               input int w, input int h);
    return {6'b0, h[grse_pkg::SIZE_W-1:0], w[grse_pkg::SIZE_W-1:0],
            y[grse_pkg::COORD_W-1:0], x[grse_pkg::COORD_W-1:0]};
  endfunction

  // Most rectangles land on or around the landscape; a few are anywhere at all.
  function automatic logic [grse_pkg::IN_TDATA_W-1:0] random_rect(input int lw, input int lh);
    int x, y, hi_x, hi_y;
    if ($urandom_range(9) == 0) begin
      x = $urandom_range(65535) - 32768;
      y = $urandom_range(65535) - 32768;
    end else begin
      hi_x = (lw + 50 > 32767) ? 32767 : lw + 50;
      hi_y = (lh + 50 > 32767) ? 32767 : lh + 50;
      x = -300 + $urandom_range(hi_x + 300);
      y = -300 + $urandom_range(hi_y + 300);
    end
    return pack_rect(x, y, $urandom_range(510) - 255, $urandom_range(510) - 255);
  endfunction

  // A valid that stays high for the next beat is not lowered in between.
  task automatic send_rect(input logic [grse_pkg::IN_TDATA_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_rect(d);
  endtask

  task automatic write_reg(input logic [grse_pkg::CFG_IDX_W-1:0] idx,
                           input logic [grse_pkg::LAND_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == grse_pkg::CFG_LANDSCAPE_WIDTH) sb.land_w = val;
    else sb.land_h = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle(input int tail);
    in_tvalid <= 1'b0;
    while (sb.owed_cells.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic run_phase(input int lw, input int lh, input int tx, input int rx,
                           input int count, input bit with_hold);
    write_reg(grse_pkg::CFG_LANDSCAPE_WIDTH, lw[grse_pkg::LAND_W-1:0]);
    write_reg(grse_pkg::CFG_LANDSCAPE_HEIGHT, lh[grse_pkg::LAND_W-1:0]);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 3) hold_req <= 1'b1;
      if (i == count / 2) settle(0);
      send_rect(random_rect(lw, lh));
    end
    settle(TAIL_CYCLES);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed beats against the reset landscape of 1024 by 1024.
    send_rect(pack_rect(0, 0, 0, 0));             // zero size at the origin is not contained
    send_rect(pack_rect(10, 10, 20, 20));
    send_rect(pack_rect(63, 63, 255, 255));       // five by five cells
    send_rect(pack_rect(1000, 1000, 100, 100));
    send_rect(pack_rect(-100, -100, 50, 50));     // wholly above and to the left
    send_rect(pack_rect(2000, 10, 10, 10));       // right of the landscape
    send_rect(pack_rect(10, 2000, 10, 10));       // below the landscape
    send_rect(pack_rect(300, 300, -255, -255));
    send_rect(pack_rect(-32768, -32768, 255, 255));
    send_rect(pack_rect(32767, 32767, -255, -255));
    send_rect(pack_rect(32767, 32767, 255, 255));
    send_rect(pack_rect(-32768, 0, -255, 10));
    send_rect(pack_rect(-50, 500, 255, 1));
    send_rect(pack_rect(0, 0, 1, 1));
    send_rect(pack_rect(1023, 1023, 1, 1));
    send_rect(pack_rect(1023, 1023, 0, 0));
    send_rect(pack_rect(1024, 0, -1, 1));
    send_rect(pack_rect(-255, -255, 255, 255));
    send_rect(pack_rect(1000, 0, 255, 255));
    send_rect(pack_rect(500, -10, -255, 255));
    settle(TAIL_CYCLES);

    run_phase(1024, 768, 0, 0, 24, 1'b1);
    run_phase(1, 1, 88, 0, 20, 1'b0);
    run_phase(65535, 65535, 0, 88, 24, 1'b0);
    run_phase(100, 65535, 13, 13, 24, 1'b0);
    run_phase($urandom_range(65535, 1), $urandom_range(65535, 1), 13, 13, 24, 1'b0);
    run_phase(65535, 1, 0, 0, 24, 1'b0);

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
